// ----- src/jdp_pkg.sv -----
package jdp_pkg;

   // Longest descriptor accepted, in bytes
   localparam int unsigned MAX_LEN = 65535;

   // Parse phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ARGS = 3'd1;
   localparam logic [2:0] PH_RET  = 3'd2;
   localparam logic [2:0] PH_OBJ  = 3'd3;
   localparam logic [2:0] PH_AOBJ = 3'd4;
   localparam logic [2:0] PH_ARR  = 3'd5;
   localparam logic [2:0] PH_TAIL = 3'd6;

   // Type kinds
   localparam logic [2:0] KIND_INT32   = 3'd0;
   localparam logic [2:0] KIND_INT64   = 3'd1;
   localparam logic [2:0] KIND_FLOAT32 = 3'd2;
   localparam logic [2:0] KIND_FLOAT64 = 3'd3;
   localparam logic [2:0] KIND_OBJECT  = 3'd4;
   localparam logic [2:0] KIND_ARRAY   = 3'd5;
   localparam logic [2:0] KIND_VOID    = 3'd6;

   // Error codes
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_NO_LPAREN = 3'd1;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ERR_VOID      = 3'd3;
   localparam logic [2:0] ERR_BAD_ARRAY = 3'd4;
   localparam logic [2:0] ERR_TRUNC     = 3'd5;
   localparam logic [2:0] ERR_TRAILING  = 3'd6;

   // Descriptor characters
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_B      = 8'h42;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_D      = 8'h44;
   localparam logic [7:0] CH_F      = 8'h46;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_J      = 8'h4A;
   localparam logic [7:0] CH_L      = 8'h4C;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_V      = 8'h56;
   localparam logic [7:0] CH_Z      = 8'h5A;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] position;
      logic [15:0] type_start;
      logic [15:0] slot_count;
      logic        is_method;
      logic        in_return;
      logic        failed;
   } state_type;

   typedef struct packed {
      logic        ch_valid;
      logic [7:0]  ch;
      logic        first;
      logic        last;
      logic        method_mode;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic        type_done;
      logic [2:0]  kind;
      logic        is_return;
      logic [15:0] type_offset;
      logic [15:0] type_length;
      logic [15:0] arg_slots;
      logic        finished;
      logic [2:0]  error;
   } result_type;

endpackage

// ----- src/jvm_descriptor_parser.sv -----
// Checks JVM field and method descriptors streamed in one byte per transfer
// (first byte flagged in tuser[0], method-or-field flag in tuser[1], final
// byte on tlast) and emits one result per completed type or per descriptor
// end, with tlast marking the end. One byte is accepted per clock when the
// result side keeps up; a byte is held in the input register, and its result
// is written to the output register once that register is free or draining.
// The throughput is set by the combinational parse step between the two
// registers, whose state feeds back to the next byte. Bytes that cause no
// result are absorbed silently.
module jvm_descriptor_parser (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [1:0]  req_tuser,   // [0] first, [1] method_mode
   input  logic        req_tlast,   // last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] type_done, [3:1] kind, [4] is_return,
                                    // [20:5] type_offset, [36:21] type_length,
                                    // [52:37] arg_slots, [55:53] error
   output logic        rsp_tlast    // finished
);

   jdp_pkg::item_type   item_ff, item_in;
   jdp_pkg::state_type  state_ff, state_in, state_next;
   jdp_pkg::result_type result;
   logic                out_valid_ff, out_valid_in;
   logic [55:0]         out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;
   logic                advance;

   jdp_step u_step (
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_next),
      .result     (result)
   );

   // the held byte moves on once the output register is free or draining
   assign advance    = item_ff.ch_valid && (!out_valid_ff || rsp_tready);
   assign req_tready = !item_ff.ch_valid || advance;

   always_comb begin
      item_in = item_ff;
      if (req_tready) begin
         item_in.ch_valid    = req_tvalid;
         item_in.ch          = req_tdata;
         item_in.first       = req_tuser[0];
         item_in.last        = req_tlast;
         item_in.method_mode = req_tuser[1];
      end

      state_in = advance ? state_next : state_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
         out_data_in  = {result.error, result.arg_slots, result.type_length,
                         result.type_offset, result.is_return, result.kind,
                         result.type_done};
         out_last_in  = result.finished;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.ch_valid    <= 1'b0;
         state_ff.phase      <= jdp_pkg::PH_IDLE;
         state_ff.position   <= '0;
         state_ff.type_start <= '0;
         state_ff.slot_count <= '0;
         state_ff.is_method  <= 1'b0;
         state_ff.in_return  <= 1'b0;
         state_ff.failed     <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         item_ff.ch_valid <= item_in.ch_valid;
         state_ff         <= state_in;
         out_valid_ff     <= out_valid_in;
      end
      item_ff.ch          <= item_in.ch;
      item_ff.first       <= item_in.first;
      item_ff.last        <= item_in.last;
      item_ff.method_mode <= item_in.method_mode;
      out_data_ff         <= out_data_in;
      out_last_ff         <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- src/jdp_step.sv -----
module jdp_step (
   input  jdp_pkg::state_type  state,
   input  jdp_pkg::item_type   item,
   output jdp_pkg::state_type  state_next,
   output jdp_pkg::result_type result
);

   jdp_pkg::state_type nxt;
   logic [15:0] p;
   logic        do_start;
   logic        do_complete;
   logic [2:0]  cmpl_kind;
   logic        do_fail;
   logic [2:0]  fail_code;
   logic [15:0] len;
   logic [16:0] slot_sum;
   logic        arg_type;

   always_comb begin
      nxt         = state;
      result      = '0;
      p           = state.position;
      do_start    = 1'b0;
      do_complete = 1'b0;
      cmpl_kind   = jdp_pkg::KIND_INT32;
      do_fail     = 1'b0;
      fail_code   = jdp_pkg::ERR_OK;
      len         = '0;
      slot_sum    = '0;
      arg_type    = 1'b0;

      if (item.ch_valid) begin
         if (item.first) begin
            nxt.is_method  = item.method_mode;
            nxt.slot_count = '0;
            nxt.in_return  = 1'b0;
            nxt.failed     = 1'b0;
            nxt.type_start = '0;
            nxt.position   = 16'd1;
            p              = '0;
            if (item.method_mode) begin
               if (item.ch != jdp_pkg::CH_LPAREN) begin
                  do_fail   = 1'b1;
                  fail_code = jdp_pkg::ERR_NO_LPAREN;
               end else begin
                  nxt.phase = jdp_pkg::PH_ARGS;
                  if (item.last) begin
                     do_fail   = 1'b1;
                     fail_code = jdp_pkg::ERR_TRUNC;
                  end
               end
            end else begin
               nxt.phase = jdp_pkg::PH_RET;
               do_start  = 1'b1;
            end
         end else if (state.phase == jdp_pkg::PH_IDLE) begin
            // stray byte outside a descriptor: dropped
         end else if (state.position >= 16'(jdp_pkg::MAX_LEN)) begin
            do_fail   = 1'b1;
            fail_code = jdp_pkg::ERR_TRUNC;
         end else begin
            nxt.position = state.position + 16'd1;
            unique case (state.phase)
               jdp_pkg::PH_ARGS: begin
                  if (item.ch == jdp_pkg::CH_RPAREN) begin
                     nxt.in_return = 1'b1;
                     nxt.phase     = jdp_pkg::PH_RET;
                     if (item.last) begin
                        do_fail   = 1'b1;
                        fail_code = jdp_pkg::ERR_TRUNC;
                     end
                  end else begin
                     do_start = 1'b1;
                  end
               end
               jdp_pkg::PH_RET: begin
                  do_start = 1'b1;
               end
               jdp_pkg::PH_OBJ, jdp_pkg::PH_AOBJ: begin
                  if (item.ch == jdp_pkg::CH_SEMI) begin
                     do_complete = 1'b1;
                     cmpl_kind   = (state.phase == jdp_pkg::PH_OBJ) ?
                                   jdp_pkg::KIND_OBJECT : jdp_pkg::KIND_ARRAY;
                  end else if (item.last) begin
                     do_fail   = 1'b1;
                     fail_code = jdp_pkg::ERR_TRUNC;
                  end
               end
               jdp_pkg::PH_ARR: begin
                  unique case (item.ch)
                     jdp_pkg::CH_LBRACK, jdp_pkg::CH_L: begin
                        if (item.ch == jdp_pkg::CH_L)
                           nxt.phase = jdp_pkg::PH_AOBJ;
                        if (item.last) begin
                           do_fail   = 1'b1;
                           fail_code = jdp_pkg::ERR_TRUNC;
                        end
                     end
                     jdp_pkg::CH_B, jdp_pkg::CH_C, jdp_pkg::CH_D, jdp_pkg::CH_F,
                     jdp_pkg::CH_I, jdp_pkg::CH_J, jdp_pkg::CH_S, jdp_pkg::CH_Z: begin
                        do_complete = 1'b1;
                        cmpl_kind   = jdp_pkg::KIND_ARRAY;
                     end
                     default: begin
                        do_fail   = 1'b1;
                        fail_code = jdp_pkg::ERR_BAD_ARRAY;
                     end
                  endcase
               end
               default: begin
                  do_fail   = 1'b1;
                  fail_code = jdp_pkg::ERR_TRAILING;
               end
            endcase
         end

         // first byte of a type
         if (do_start) begin
            nxt.type_start = p;
            unique case (item.ch)
               jdp_pkg::CH_B, jdp_pkg::CH_C, jdp_pkg::CH_I, jdp_pkg::CH_S,
               jdp_pkg::CH_Z: begin
                  do_complete = 1'b1;
                  cmpl_kind   = jdp_pkg::KIND_INT32;
               end
               jdp_pkg::CH_J: begin
                  do_complete = 1'b1;
                  cmpl_kind   = jdp_pkg::KIND_INT64;
               end
               jdp_pkg::CH_F: begin
                  do_complete = 1'b1;
                  cmpl_kind   = jdp_pkg::KIND_FLOAT32;
               end
               jdp_pkg::CH_D: begin
                  do_complete = 1'b1;
                  cmpl_kind   = jdp_pkg::KIND_FLOAT64;
               end
               jdp_pkg::CH_V: begin
                  if (!nxt.in_return) begin
                     do_fail   = 1'b1;
                     fail_code = jdp_pkg::ERR_VOID;
                  end else begin
                     do_complete = 1'b1;
                     cmpl_kind   = jdp_pkg::KIND_VOID;
                  end
               end
               jdp_pkg::CH_L, jdp_pkg::CH_LBRACK: begin
                  nxt.phase = (item.ch == jdp_pkg::CH_L) ?
                              jdp_pkg::PH_OBJ : jdp_pkg::PH_ARR;
                  if (item.last) begin
                     do_fail   = 1'b1;
                     fail_code = jdp_pkg::ERR_TRUNC;
                  end
               end
               default: begin
                  do_fail   = 1'b1;
                  fail_code = jdp_pkg::ERR_BAD_TYPE;
               end
            endcase
         end

         if (do_complete) begin
            len      = p - nxt.type_start + 16'd1;
            arg_type = nxt.is_method && !nxt.in_return;
            result.valid       = 1'b1;
            result.type_done   = 1'b1;
            result.kind        = cmpl_kind;
            result.type_offset = nxt.type_start;
            result.type_length = len;
            if (arg_type) begin
               slot_sum = {1'b0, nxt.slot_count} +
                          ((cmpl_kind == jdp_pkg::KIND_INT64 ||
                            cmpl_kind == jdp_pkg::KIND_FLOAT64) ? 17'd2 : 17'd1);
               nxt.slot_count = slot_sum[16] ? 16'hFFFF : slot_sum[15:0];
               nxt.phase      = jdp_pkg::PH_ARGS;
               if (item.last) begin
                  // argument ends the descriptor: still truncated
                  nxt.failed      = 1'b1;
                  nxt.phase       = jdp_pkg::PH_IDLE;
                  result.finished = 1'b1;
                  result.error    = jdp_pkg::ERR_TRUNC;
               end
            end else begin
               result.is_return = nxt.in_return;
               if (item.last) begin
                  nxt.phase       = jdp_pkg::PH_IDLE;
                  result.finished = 1'b1;
               end else begin
                  nxt.phase = jdp_pkg::PH_TAIL;
               end
            end
         end

         if (do_fail) begin
            nxt.failed      = 1'b1;
            nxt.phase       = jdp_pkg::PH_IDLE;
            result.valid    = 1'b1;
            result.finished = 1'b1;
            result.error    = fail_code;
         end
      end

      result.arg_slots = nxt.slot_count;
      state_next       = nxt;
   end

endmodule

// ----- tb/jvm_descriptor_parser_tb.sv -----
`timescale 1ns / 1ps

module jvm_descriptor_parser_tb;
   import jdp_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic        type_done;
      logic [2:0]  kind;
      logic        is_return;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] slots;
      logic        finished;
      logic [2:0]  error;
   } type_report_type;

   // Tracks the parse of the descriptor stream and holds the type reports still due.
   class descriptor_scoreboard;
      logic [2:0]      phase;
      int unsigned     position;
      int unsigned     type_start;
      int unsigned     slot_count;
      bit              is_method;
      bit              in_return;
      type_report_type type_reports[$];
      int unsigned     mismatches;

      function new();
         phase = PH_IDLE;
         position = 0;
         type_start = 0;
         slot_count = 0;
         is_method = 0;
         in_return = 0;
         mismatches = 0;
      endfunction

      function void push_report(bit done, logic [2:0] kind, bit ret, int unsigned off,
                                int unsigned len, bit fin, logic [2:0] err);
         type_report_type r;
         r.type_done = done;
         r.kind = kind;
         r.is_return = ret;
         r.offset = off[15:0];
         r.length = len[15:0];
         r.slots = slot_count[15:0];
         r.finished = fin;
         r.error = err;
         type_reports.insert(type_reports.size(), r);
      endfunction

      function void abort(logic [2:0] err);
         phase = PH_IDLE;
         push_report(1'b0, '0, 1'b0, 0, 0, 1'b1, err);
      endfunction

      function void close_type(logic [2:0] kind, int unsigned p, bit last_byte);
         int unsigned len;
         len = p - type_start + 1;
         if (is_method && !in_return) begin
            slot_count += (kind == KIND_INT64 || kind == KIND_FLOAT64) ? 2 : 1;
            if (slot_count > 32'h0000_FFFF) slot_count = 32'h0000_FFFF;
            if (last_byte) begin
               // argument list cut short right after a complete argument
               phase = PH_IDLE;
               push_report(1'b1, kind, 1'b0, type_start, len, 1'b1, ERR_TRUNC);
            end else begin
               phase = PH_ARGS;
               push_report(1'b1, kind, 1'b0, type_start, len, 1'b0, ERR_OK);
            end
         end else begin
            phase = last_byte ? PH_IDLE : PH_TAIL;
            push_report(1'b1, kind, in_return, type_start, len, last_byte, ERR_OK);
         end
      endfunction

      function void open_type(logic [7:0] c, int unsigned p, bit last_byte);
         type_start = p;
         case (c)
            CH_B, CH_C, CH_I, CH_S, CH_Z: begin
               close_type(KIND_INT32, p, last_byte);
               return;
            end
            CH_J: begin
               close_type(KIND_INT64, p, last_byte);
               return;
            end
            CH_F: begin
               close_type(KIND_FLOAT32, p, last_byte);
               return;
            end
            CH_D: begin
               close_type(KIND_FLOAT64, p, last_byte);
               return;
            end
            CH_V: begin
               if (!in_return) abort(ERR_VOID);
               else close_type(KIND_VOID, p, last_byte);
               return;
            end
            CH_L: phase = PH_OBJ;
            CH_LBRACK: phase = PH_ARR;
            default: begin
               abort(ERR_BAD_TYPE);
               return;
            end
         endcase
         if (last_byte) abort(ERR_TRUNC);
      endfunction

      function void note_byte(logic [7:0] c, bit first_byte, bit last_byte, bit method_mode);
         int unsigned p;
         if (first_byte) begin
            is_method = method_mode;
            slot_count = 0;
            in_return = 0;
            type_start = 0;
            position = 1;
            if (is_method) begin
               if (c != CH_LPAREN) abort(ERR_NO_LPAREN);
               else begin
                  phase = PH_ARGS;
                  if (last_byte) abort(ERR_TRUNC);
               end
            end else begin
               phase = PH_RET;
               open_type(c, 0, last_byte);
            end
            return;
         end
         if (phase == PH_IDLE) return;
         if (position >= MAX_LEN) begin
            abort(ERR_TRUNC);
            return;
         end
         p = position;
         position = p + 1;
         case (phase)
            PH_ARGS: begin
               if (c == CH_RPAREN) begin
                  in_return = 1;
                  phase = PH_RET;
                  if (last_byte) abort(ERR_TRUNC);
               end else begin
                  open_type(c, p, last_byte);
               end
            end
            PH_RET: open_type(c, p, last_byte);
            PH_OBJ, PH_AOBJ: begin
               if (c == CH_SEMI)
                  close_type(phase == PH_OBJ ? KIND_OBJECT : KIND_ARRAY, p, last_byte);
               else if (last_byte)
                  abort(ERR_TRUNC);
            end
            PH_ARR: begin
               case (c)
                  CH_LBRACK: begin
                     if (last_byte) abort(ERR_TRUNC);
                  end
                  CH_L: begin
                     phase = PH_AOBJ;
                     if (last_byte) abort(ERR_TRUNC);
                  end
                  CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z:
                     close_type(KIND_ARRAY, p, last_byte);
                  default: abort(ERR_BAD_ARRAY);
               endcase
            end
            default: abort(ERR_TRAILING);
         endcase
      endfunction

      function string fmt(type_report_type r);
         return $sformatf("done=%0d kind=%0d ret=%0d off=%0d len=%0d slots=%0d fin=%0d err=%0d",
                          r.type_done, r.kind, r.is_return, r.offset, r.length, r.slots,
                          r.finished, r.error);
      endfunction

      function void check_report(logic [55:0] d, logic fin);
         type_report_type got;
         type_report_type want;
         got.type_done = d[0];
         got.kind = d[3:1];
         got.is_return = d[4];
         got.offset = d[20:5];
         got.length = d[36:21];
         got.slots = d[52:37];
         got.error = d[55:53];
         got.finished = fin;
         if (type_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", fmt(got));
            return;
         end
         want = type_reports.pop_front();
         if (got.type_done !== want.type_done || got.kind !== want.kind ||
             got.is_return !== want.is_return || got.offset !== want.offset ||
             got.length !== want.length || got.slots !== want.slots ||
             got.finished !== want.finished || got.error !== want.error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %s\n          got      %s", fmt(want), fmt(got));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;

   descriptor_scoreboard sb = new();
   logic [7:0]  desc_bytes[$];
   logic [7:0]  prim_codes[8] = '{CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z};
   bit          no_gaps = 0;
   int          bytes_sent = 0;
   int          stall_cycles = 0;

   jvm_descriptor_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata, req_tuser[0], req_tlast, req_tuser[1]);
         if (rsp_tvalid && rsp_tready)
            sb.check_report(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall ahead of every transfer
   initial begin : rsp_side
      int gap;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic void add_byte(input logic [7:0] b);
      desc_bytes.insert(desc_bytes.size(), b);
   endfunction

   task automatic send_byte(input logic [7:0] c, input bit f, input bit l, input bit m);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= {m, f};
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // method flag only matters on the first byte; elsewhere it toggles freely
   task automatic send_descriptor(input bit m, input bit mark_last);
      int n;
      n = desc_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(desc_bytes[i], i == 0, mark_last && i == n - 1,
                   i == 0 ? m : 1'($urandom_range(0, 1)));
   endtask

   task automatic send_text(input string s, input bit m);
      desc_bytes.delete();
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
      send_descriptor(m, 1'b1);
   endtask

   task automatic add_type(input bit allow_void);
      int choice;
      int n;
      choice = $urandom_range(0, 9);
      if (choice == 9 && !allow_void) choice = 0;
      if (choice >= 7 && choice <= 8) begin
         repeat ($urandom_range(1, 3)) add_byte(CH_LBRACK);
         choice = $urandom_range(0, 1) ? 0 : 5;
      end
      if (choice <= 4) begin
         add_byte(prim_codes[3'($urandom_range(0, 7))]);
      end else if (choice <= 6) begin
         add_byte(CH_L);
         n = $urandom_range(0, 6);
         repeat (n) add_byte(8'($urandom_range(0, 7) == 0 ? "/" : $urandom_range(97, 122)));
         add_byte(CH_SEMI);
      end else begin
         add_byte(CH_V);
      end
   endtask

   task automatic build_descriptor(input bit m);
      desc_bytes.delete();
      if (m) begin
         add_byte(CH_LPAREN);
         repeat ($urandom_range(0, 4)) add_type(1'b0);
         add_byte(CH_RPAREN);
         add_type(1'b1);
      end else begin
         add_type($urandom_range(0, 9) == 0);
      end
   endtask

   task automatic run_random();
      int  r;
      int  cut;
      bit  m;
      bit  mark_last;
      while (bytes_sent < 900) begin
         no_gaps = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 99) < 8) begin
            // stray bytes, mostly outside any descriptor
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            continue;
         end
         m = ($urandom_range(0, 9) < 6);
         build_descriptor(m);
         mark_last = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 70) begin
         end else if (r < 78) begin
            desc_bytes[$urandom_range(0, desc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (r < 88) begin
            cut = $urandom_range(0, desc_bytes.size() - 1);
            while (desc_bytes.size() > cut + 1) void'(desc_bytes.pop_back());
            // some truncated descriptors are abandoned for a restart
            mark_last = (r < 84);
         end else if (r < 93) begin
            repeat ($urandom_range(1, 2))
               add_byte($urandom_range(0, 1) ? CH_I : 8'($urandom_range(0, 255)));
         end else if (r < 97) begin
            m = !m;
         end else begin
            desc_bytes.delete();
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         end
         send_descriptor(m, mark_last);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_text("(IJ)V", 1'b1);
      send_text("(BCDFSZ)I", 1'b1);
      send_text("(Lx;[JL;[[Lq;)[D", 1'b1);
      send_text("()V", 1'b1);
      send_text("Ljava/lang/Object;", 1'b0);
      send_text("[[I", 1'b0);
      send_text("L;", 1'b0);
      send_text("V", 1'b0);
      send_text("(V)V", 1'b1);
      send_text("I", 1'b1);
      send_text("Q", 1'b0);
      send_text("[X", 1'b0);
      send_text("(I", 1'b1);
      send_text("(", 1'b1);
      send_text("(I)", 1'b1);
      send_text("[L", 1'b0);
      send_text("Labc", 1'b0);
      send_text("II", 1'b0);
      send_text("(I)VJ", 1'b1);
      // bytes while idle are dropped
      send_byte(8'hFF, 1'b0, 1'b1, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0, 1'b0);
      // restart in the middle of an argument list
      desc_bytes = '{CH_LPAREN, CH_I, CH_J};
      send_descriptor(1'b1, 1'b0);
      desc_bytes = '{8'h00};
      send_descriptor(1'b0, 1'b1);
      desc_bytes = '{8'hFF};
      send_descriptor(1'b0, 1'b1);

      run_random();

      req_tvalid <= 1'b0;
      while (sb.type_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
